// ===== hw/rtl/pbr_pkg.sv =====
// ----------------------------------------------------------------------------
// pbr_pkg
// Shared constants, request codes, controller states and command types for
// the PCA basis reconstruction unit.
// ----------------------------------------------------------------------------
package pbr_pkg;

  localparam int ROWS       = 1024;
  localparam int COMPONENTS = 64;

  localparam int OP_W    = 3;
  localparam int ROW_W   = 10;
  localparam int COMP_W  = 6;
  localparam int VAL_W   = 32;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int ACC_W   = 64;

  localparam int BASIS_AW    = 1 + ROW_W + COMP_W;
  localparam int BASIS_DEPTH = 2 * ROWS * COMPONENTS;
  localparam int MEAN_AW     = 1 + ROW_W;
  localparam int MEAN_DEPTH  = 2 * ROWS;
  localparam int COEF_AW     = 1 + COMP_W;
  localparam int COEF_DEPTH  = 2 * COMPONENTS;

  localparam int DIVISOR    = 1000;
  localparam int ROUND_DIV  = DIVISOR / 2;
  localparam int QUO_W      = 32;
  localparam int DIV_PRE    = 3;
  localparam int DIV_ODD    = DIVISOR >> DIV_PRE;
  localparam int DIV_Y_W    = $clog2(DIV_ODD) + QUO_W;
  localparam int RECIP_SH   = DIV_Y_W + $clog2(DIV_ODD);
  localparam int HALF_W     = (DIV_Y_W + 1) / 2;
  localparam int RPROD_W    = 4 * HALF_W;
  localparam int DIV_STEPS  = 4;
  localparam int CNT_W      = (COMP_W > $clog2(DIV_STEPS)) ? COMP_W : $clog2(DIV_STEPS);

  localparam logic [2*HALF_W-1:0] RECIP =
    (2 * HALF_W)'(((64'd1 << RECIP_SH) + 64'(DIV_ODD - 1)) / 64'(DIV_ODD));

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [VAL_W-1:0]  VAL_MAX    = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0]  VAL_MIN    = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [QUO_W-1:0]         NEG_LIMIT  = {1'b1, {(QUO_W-1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_BASIS = 3'd0,
    OP_LOAD_MEAN  = 3'd1,
    OP_LOAD_SCALE = 3'd2,
    OP_LOAD_COEFF = 3'd3,
    OP_COMPUTE    = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ABS,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic              issue;
    logic [COMP_W-1:0] comp;
    logic              take_abs;
    logic              div_load;
    logic              div_step;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } status_t;

  function automatic logic row_ok(input logic [ROW_W-1:0] r);
    return {1'b0, r} < (ROW_W + 1)'(ROWS);
  endfunction

  function automatic logic comp_ok(input logic [COMP_W-1:0] c);
    return {1'b0, c} < (COMP_W + 1)'(COMPONENTS);
  endfunction

endpackage

// ===== hw/rtl/pca_basis_reconstruct_unit.sv =====
// ----------------------------------------------------------------------------
// pca_basis_reconstruct_unit
// Two-model linear PCA reconstruction of a single element per request.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid/in_stall with op, model, row, component, value
//   load requests (basis, mean, scale, coefficient) write one entry each; they
//   give no result
//   a compute request for an in-range row gives one result on
//   out_valid/out_stall: model, row, (mean + sum basis*scale*coeff) / 1000
//   in Q16.16 and a saturation flag
//   a compute issues the components into the single multiply-accumulate
//   pipeline, drains it, takes magnitude and bias, does the reciprocal
//   multiply for the divide by 1000 and hands the result off
//   in_stall is high for the whole compute, so a new request waits until it
//   is through; loads stream at one per cycle while no compute runs
//   a finished result sits in the output register; if out_stall holds it,
//   the next compute waits at its last step until the register frees up
//   reset clears control only; store contents are undefined until loaded
// ----------------------------------------------------------------------------
module pca_basis_reconstruct_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [pbr_pkg::OP_W-1:0]         in_op,
  input  logic                             in_model,
  input  logic [pbr_pkg::ROW_W-1:0]        in_row,
  input  logic [pbr_pkg::COMP_W-1:0]       in_component,
  input  logic signed [pbr_pkg::VAL_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_model,
  output logic [pbr_pkg::ROW_W-1:0]        out_row,
  output logic signed [pbr_pkg::VAL_W-1:0] out_value,
  output logic                             out_saturated
);
  import pbr_pkg::*;

  cmd_t                    cmd;
  status_t                 status;
  logic                    in_accept, pipe_busy, w_sat, res_sat, cur_model;
  logic [ROW_W-1:0]        cur_row;
  logic signed [ACC_W-1:0] acc;
  logic signed [VAL_W-1:0] res_value;

  logic                    out_valid_r;
  logic                    out_model_r, out_sat_r;
  logic [ROW_W-1:0]        out_row_r;
  logic signed [VAL_W-1:0] out_value_r;

  assign in_accept        = in_valid && !in_stall;
  assign status.pipe_busy = pipe_busy;
  assign status.out_free  = !out_valid_r || !out_stall;

  pbr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_row   (in_row),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  pbr_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_accept    (in_accept),
    .in_op        (in_op),
    .in_model     (in_model),
    .in_row       (in_row),
    .in_component (in_component),
    .in_value     (in_value),
    .cmd          (cmd),
    .pipe_busy    (pipe_busy),
    .acc          (acc),
    .w_sat        (w_sat),
    .cur_model    (cur_model),
    .cur_row      (cur_row)
  );

  pbr_div u_div (
    .clk       (clk),
    .cmd       (cmd),
    .acc       (acc),
    .res_value (res_value),
    .res_sat   (res_sat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_model_r <= cur_model;
      out_row_r   <= cur_row;
      out_value_r <= res_value;
      out_sat_r   <= w_sat || res_sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_model     = out_model_r;
  assign out_row       = out_row_r;
  assign out_value     = out_value_r;
  assign out_saturated = out_sat_r;

  a_compute_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_op == OP_COMPUTE) && row_ok(in_row) |=> in_stall)
    else $error("compute request did not stall the input");

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_busy |-> in_stall)
    else $error("mac pipeline busy while input open");

  a_result_from_compute: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared outside a compute");

endmodule

// ===== hw/rtl/pbr_ctrl.sv =====
// ----------------------------------------------------------------------------
// pbr_ctrl
// Sequencer: walks one compute request through component issue, pipeline
// drain, magnitude, reciprocal divide and result hand-off.
// ----------------------------------------------------------------------------
module pbr_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [pbr_pkg::OP_W-1:0]  in_op,
  input  logic [pbr_pkg::ROW_W-1:0] in_row,
  input  pbr_pkg::status_t          status,
  output logic                      in_stall,
  output pbr_pkg::cmd_t             cmd
);
  import pbr_pkg::*;

  localparam logic [CNT_W-1:0] COMP_LAST = CNT_W'(COMPONENTS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             start;

  assign start = in_valid && (state_r == ST_IDLE) && (in_op == OP_COMPUTE) && row_ok(in_row);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (start) state_nxt = ST_MAC;
      end
      ST_MAC: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == COMP_LAST) begin
          state_nxt = ST_DRAIN;
          cnt_nxt   = '0;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) state_nxt = ST_ABS;
      end
      ST_ABS: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        state_nxt = ST_DIV;
        cnt_nxt   = '0;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_DONE;
          cnt_nxt   = '0;
        end
      end
      ST_DONE: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall     = (state_r != ST_IDLE);
    cmd          = '0;
    cmd.start    = start;
    cmd.comp     = cnt_r[COMP_W-1:0];
    unique case (state_r)
      ST_MAC:  cmd.issue    = 1'b1;
      ST_ABS:  cmd.take_abs = 1'b1;
      ST_LOAD: cmd.div_load = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_DONE: cmd.out_load = status.out_free;
      default: cmd.issue    = 1'b0;
    endcase
  end

endmodule

// ===== hw/rtl/pbr_dp.sv =====
// ----------------------------------------------------------------------------
// pbr_dp
// Model stores and the weighted multiply-accumulate pipeline: one component
// per cycle, scale times coefficient, then basis times weight, into a 64-bit
// accumulator seeded with the mean.
// ----------------------------------------------------------------------------
module pbr_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_accept,
  input  logic [pbr_pkg::OP_W-1:0]         in_op,
  input  logic                             in_model,
  input  logic [pbr_pkg::ROW_W-1:0]        in_row,
  input  logic [pbr_pkg::COMP_W-1:0]       in_component,
  input  logic signed [pbr_pkg::VAL_W-1:0] in_value,
  input  pbr_pkg::cmd_t                    cmd,
  output logic                             pipe_busy,
  output logic signed [pbr_pkg::ACC_W-1:0] acc,
  output logic                             w_sat,
  output logic                             cur_model,
  output logic [pbr_pkg::ROW_W-1:0]        cur_row
);
  import pbr_pkg::*;

  logic signed [VAL_W-1:0] basis_mem [BASIS_DEPTH];
  logic signed [VAL_W-1:0] mean_mem  [MEAN_DEPTH];
  logic signed [VAL_W-1:0] scale_mem [COEF_DEPTH];
  logic signed [VAL_W-1:0] coeff_mem [COEF_DEPTH];

  logic                    model_r;
  logic [ROW_W-1:0]        row_r;
  logic                    v1_r, v2_r, v3_r, v4_r, v5_r, first1_r;
  logic signed [VAL_W-1:0] s_q_r, c_q_r, b_q_r, mean_q_r;
  logic signed [VAL_W-1:0] b2_r, b3_r, w_r;
  logic signed [PROD_W-1:0] p1_r, p2_r, t_r;
  logic signed [ACC_W-1:0] acc_r;
  logic                    sat_r;

  logic                    row_in_ok, comp_in_ok;
  logic [BASIS_AW-1:0]     basis_waddr, basis_raddr;
  logic [MEAN_AW-1:0]      mean_waddr, mean_raddr;
  logic [COEF_AW-1:0]      coef_waddr, coef_raddr;
  logic signed [PROD_W-1:0] w_rnd;
  logic                    w_hi, w_lo;

  assign row_in_ok   = row_ok(in_row);
  assign comp_in_ok  = comp_ok(in_component);
  assign basis_waddr = {in_model, in_row, in_component};
  assign mean_waddr  = {in_model, in_row};
  assign coef_waddr  = {in_model, in_component};
  assign basis_raddr = {model_r, row_r, cmd.comp};
  assign mean_raddr  = {model_r, row_r};
  assign coef_raddr  = {model_r, cmd.comp};

  always_ff @(posedge clk) begin
    if (in_accept && (in_op == OP_LOAD_BASIS) && row_in_ok && comp_in_ok) begin
      basis_mem[basis_waddr] <= in_value;
    end
    b_q_r <= basis_mem[basis_raddr];
  end

  always_ff @(posedge clk) begin
    if (in_accept && (in_op == OP_LOAD_MEAN) && row_in_ok) begin
      mean_mem[mean_waddr] <= in_value;
    end
    mean_q_r <= mean_mem[mean_raddr];
  end

  always_ff @(posedge clk) begin
    if (in_accept && (in_op == OP_LOAD_SCALE) && comp_in_ok) begin
      scale_mem[coef_waddr] <= in_value;
    end
    s_q_r <= scale_mem[coef_raddr];
  end

  always_ff @(posedge clk) begin
    if (in_accept && (in_op == OP_LOAD_COEFF) && comp_in_ok) begin
      coeff_mem[coef_waddr] <= in_value;
    end
    c_q_r <= coeff_mem[coef_raddr];
  end

  // weight rounding and clamp
  assign w_rnd = (p1_r + ROUND_HALF) >>> FRAC_W;
  assign w_hi  = w_rnd > PROD_W'(VAL_MAX);
  assign w_lo  = w_rnd < PROD_W'(VAL_MIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      v4_r     <= 1'b0;
      v5_r     <= 1'b0;
      first1_r <= 1'b0;
    end else begin
      v1_r     <= cmd.issue;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      v4_r     <= v3_r;
      v5_r     <= v4_r;
      first1_r <= cmd.issue && (cmd.comp == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      model_r <= in_model;
      row_r   <= in_row;
    end
    p1_r <= $signed(PROD_W'(s_q_r)) * $signed(PROD_W'(c_q_r));
    b2_r <= b_q_r;
    if (w_hi) begin
      w_r <= VAL_MAX;
    end else if (w_lo) begin
      w_r <= VAL_MIN;
    end else begin
      w_r <= w_rnd[VAL_W-1:0];
    end
    b3_r <= b2_r;
    p2_r <= $signed(PROD_W'(b3_r)) * $signed(PROD_W'(w_r));
    t_r  <= (p2_r + ROUND_HALF) >>> FRAC_W;
    if (cmd.start) begin
      sat_r <= 1'b0;
    end else if (v2_r && (w_hi || w_lo)) begin
      sat_r <= 1'b1;
    end
    if (first1_r) begin
      acc_r <= $signed(ACC_W'(mean_q_r));
    end else if (v5_r) begin
      acc_r <= acc_r + ACC_W'(t_r);
    end
  end

  assign pipe_busy = v1_r || v2_r || v3_r || v4_r || v5_r;
  assign acc       = acc_r;
  assign w_sat     = sat_r;
  assign cur_model = model_r;
  assign cur_row   = row_r;

endmodule

// ===== hw/rtl/pbr_div.sv =====
// ----------------------------------------------------------------------------
// pbr_div
// Rounded division of the accumulator by 1000: magnitude, half-divisor bias,
// reciprocal multiplication in four 20 by 20 bit partial products, then sign
// and 32-bit clamp.
// ----------------------------------------------------------------------------
module pbr_div (
  input  logic                             clk,
  input  pbr_pkg::cmd_t                    cmd,
  input  logic signed [pbr_pkg::ACC_W-1:0] acc,
  output logic signed [pbr_pkg::VAL_W-1:0] res_value,
  output logic                             res_sat
);
  import pbr_pkg::*;

  localparam logic [ACC_W-1:0] DIV_LIMIT = ACC_W'(DIVISOR) << QUO_W;

  logic [ACC_W-1:0]    mag_r;
  logic                neg_r, big_r;
  logic [2*HALF_W-1:0] y_r;
  logic [RPROD_W-1:0]  prod_r;
  logic [ACC_W-1:0]    biased;
  logic [HALF_W-1:0]   pp_a, pp_b;
  logic [2*HALF_W-1:0] pp;
  logic [RPROD_W-1:0]  addend;
  logic [QUO_W-1:0]    q;

  assign biased = mag_r + ACC_W'(ROUND_DIV);
  assign pp_a   = cmd.comp[1] ? y_r[2*HALF_W-1:HALF_W] : y_r[HALF_W-1:0];
  assign pp_b   = cmd.comp[0] ? RECIP[2*HALF_W-1:HALF_W] : RECIP[HALF_W-1:0];
  assign pp     = pp_a * pp_b;
  assign q      = prod_r[RECIP_SH +: QUO_W];

  // partial product weight follows the halves taken
  always_comb begin
    if (cmd.comp[1] && cmd.comp[0]) begin
      addend = {pp, {(2*HALF_W){1'b0}}};
    end else if (cmd.comp[1] || cmd.comp[0]) begin
      addend = {{HALF_W{1'b0}}, pp, {HALF_W{1'b0}}};
    end else begin
      addend = {{(2*HALF_W){1'b0}}, pp};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_abs) begin
      neg_r <= acc[ACC_W-1];
      mag_r <= acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    end
    if (cmd.div_load) begin
      big_r  <= biased >= DIV_LIMIT;
      y_r    <= biased[DIV_PRE +: 2*HALF_W];
      prod_r <= '0;
    end else if (cmd.div_step) begin
      prod_r <= prod_r + addend;
    end
  end

  always_comb begin
    res_sat   = 1'b0;
    res_value = $signed(q);
    if (big_r) begin
      res_sat   = 1'b1;
      res_value = neg_r ? VAL_MIN : VAL_MAX;
    end else if (!neg_r) begin
      if (q[QUO_W-1]) begin
        res_sat   = 1'b1;
        res_value = VAL_MAX;
      end
    end else if (q > NEG_LIMIT) begin
      res_sat   = 1'b1;
      res_value = VAL_MIN;
    end else begin
      res_value = $signed(~q + QUO_W'(1));
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pca_basis_reconstruct_unit. Loads basis, mean,
// scale and coefficient entries for both models, then requests row
// reconstructions and checks each result against an in-bench fixed-point
// predictor. It covers directed extremes, rounding and saturation, ignored
// opcodes, a long output hold-off and a long random mix, with random idling
// on both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pbr_pkg::*;

  localparam int RANDOM_ITEMS   = 600;
  localparam int IDLE_PCT       = 14;
  localparam int HOLD_CYCLES    = 500;
  localparam int DRAIN_CYCLES   = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SMALL_W        = 1 << FRAC_W;

  typedef struct {
    logic                    model;
    logic [ROW_W-1:0]        row;
    logic signed [VAL_W-1:0] value;
    logic                    sat;
  } element_t;

  logic                    clk           = 1'b0;
  logic                    rst_n         = 1'b0;
  logic                    in_valid      = 1'b0;
  logic                    in_stall;
  logic [OP_W-1:0]         in_op         = '0;
  logic                    in_model      = 1'b0;
  logic [ROW_W-1:0]        in_row        = '0;
  logic [COMP_W-1:0]       in_component  = '0;
  logic signed [VAL_W-1:0] in_value      = '0;
  logic                    out_valid;
  logic                    out_stall     = 1'b0;
  logic                    out_model;
  logic [ROW_W-1:0]        out_row;
  logic signed [VAL_W-1:0] out_value;
  logic                    out_saturated;

  logic signed [VAL_W-1:0] basis_mem [BASIS_DEPTH];
  logic signed [VAL_W-1:0] mean_mem  [MEAN_DEPTH];
  logic signed [VAL_W-1:0] scale_mem [COEF_DEPTH];
  logic signed [VAL_W-1:0] coeff_mem [COEF_DEPTH];
  bit                      row_full  [MEAN_DEPTH];
  logic [MEAN_AW-1:0]      full_rows [$];
  element_t                pending_elems [$];
  element_t                want;

  int   fails         = 0;
  int   requests_sent = 0;
  int   quiet_cycles  = 0;
  int   hold_left     = 0;
  logic idling_on     = 1'b1;
  logic hold_toggle   = 1'b0;
  logic hold_seen     = 1'b0;

  pca_basis_reconstruct_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_model      (in_model),
    .in_row        (in_row),
    .in_component  (in_component),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_model     (out_model),
    .out_row       (out_row),
    .out_value     (out_value),
    .out_saturated (out_saturated)
  );

  always #2 clk = ~clk;

  function automatic longint clamp_val(input longint x, inout logic sat);
    if (x > longint'(VAL_MAX)) begin
      sat = 1'b1;
      return longint'(VAL_MAX);
    end
    if (x < longint'(VAL_MIN)) begin
      sat = 1'b1;
      return longint'(VAL_MIN);
    end
    return x;
  endfunction

  function automatic element_t predict_element(input logic m, input logic [ROW_W-1:0] r);
    element_t e;
    longint   acc;
    longint   w;
    longint   mag;
    longint   q;
    logic     sat;
    int       k;
    sat = 1'b0;
    acc = longint'(mean_mem[{m, r}]);
    for (k = 0; k < COMPONENTS; k++) begin
      w = longint'(scale_mem[{m, COMP_W'(k)}]) * longint'(coeff_mem[{m, COMP_W'(k)}]);
      w = clamp_val((w + ROUND_HALF) >>> FRAC_W, sat);
      acc += (longint'(basis_mem[{m, r, COMP_W'(k)}]) * w + ROUND_HALF) >>> FRAC_W;
    end
    mag = (acc < 0) ? -acc : acc;
    q   = (mag + ROUND_DIV) / DIVISOR;
    if (acc < 0) q = -q;
    e.model = m;
    e.row   = r;
    e.value = VAL_W'(clamp_val(q, sat));
    e.sat   = sat;
    return e;
  endfunction

  task automatic apply_request(input logic [OP_W-1:0] op, input logic m,
                               input logic [ROW_W-1:0] r, input logic [COMP_W-1:0] c,
                               input logic signed [VAL_W-1:0] v);
    case (op)
      OP_LOAD_BASIS: if (r < ROWS && c < COMPONENTS) basis_mem[{m, r, c}] = v;
      OP_LOAD_MEAN:  if (r < ROWS) mean_mem[{m, r}] = v;
      OP_LOAD_SCALE: if (c < COMPONENTS) scale_mem[{m, c}] = v;
      OP_LOAD_COEFF: if (c < COMPONENTS) coeff_mem[{m, c}] = v;
      OP_COMPUTE:    if (r < ROWS) pending_elems.push_back(predict_element(m, r));
      default: ;
    endcase
  endtask

  task automatic send_request(input logic [OP_W-1:0] op, input logic m,
                              input logic [ROW_W-1:0] r, input logic [COMP_W-1:0] c,
                              input logic signed [VAL_W-1:0] v);
    if (idling_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_model     <= m;
    in_row       <= r;
    in_component <= c;
    in_value     <= v;
    do @(posedge clk); while (in_stall);
    apply_request(op, m, r, c, v);
    if (op <= OP_COMPUTE) requests_sent++;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      3, 4, 5: return VAL_W'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_weight();
    return VAL_W'(int'($urandom_range(0, 2 * SMALL_W)) - SMALL_W);
  endfunction

  function automatic logic [COMP_W-1:0] any_comp();
    return COMP_W'($urandom_range(0, COMPONENTS - 1));
  endfunction

  function automatic logic [ROW_W-1:0] any_row();
    return ROW_W'($urandom_range(0, ROWS - 1));
  endfunction

  task automatic fill_row(input logic m, input logic [ROW_W-1:0] r, input bit fixed,
                          input logic signed [VAL_W-1:0] fixed_val);
    logic [MEAN_AW-1:0] idx;
    int                 k;
    idx = {m, r};
    for (k = 0; k < COMPONENTS; k++)
      send_request(OP_LOAD_BASIS, m, r, COMP_W'(k), fixed ? fixed_val : pick_value());
    send_request(OP_LOAD_MEAN, m, r, any_comp(), fixed ? fixed_val : pick_value());
    if (!row_full[idx]) begin
      row_full[idx] = 1'b1;
      full_rows.push_back(idx);
    end
  endtask

  task automatic load_weights(input logic m, input bit fixed,
                              input logic signed [VAL_W-1:0] fixed_val);
    int k;
    for (k = 0; k < COMPONENTS; k++) begin
      send_request(OP_LOAD_SCALE, m, any_row(), COMP_W'(k), fixed ? fixed_val : pick_weight());
      send_request(OP_LOAD_COEFF, m, any_row(), COMP_W'(k), fixed ? fixed_val : pick_weight());
    end
  endtask

  task automatic compute_row(input logic m, input logic [ROW_W-1:0] r);
    send_request(OP_COMPUTE, m, r, any_comp(), VAL_W'($urandom));
  endtask

  task automatic compute_any_full();
    logic [MEAN_AW-1:0] idx;
    idx = full_rows[$urandom_range(0, full_rows.size() - 1)];
    compute_row(idx[ROW_W], idx[ROW_W-1:0]);
  endtask

  task automatic test_extremes();
    logic signed [VAL_W-1:0] means [8];
    means = '{500, 499, -500, -499, 1499, -1500, VAL_MAX, VAL_MIN};
    load_weights(1'b0, 1'b1, VAL_MAX);
    fill_row(1'b0, '0, 1'b1, VAL_MAX);
    compute_row(1'b0, '0);
    fill_row(1'b0, ROW_W'(ROWS - 1), 1'b1, VAL_MIN);
    compute_row(1'b0, ROW_W'(ROWS - 1));
    load_weights(1'b0, 1'b1, VAL_MIN);
    compute_row(1'b0, '0);
    load_weights(1'b1, 1'b1, '0);
    fill_row(1'b1, ROW_W'(ROWS - 1), 1'b1, '0);
    foreach (means[i]) begin
      send_request(OP_LOAD_MEAN, 1'b1, ROW_W'(ROWS - 1), any_comp(), means[i]);
      compute_row(1'b1, ROW_W'(ROWS - 1));
    end
    load_weights(1'b0, 1'b0, '0);
    load_weights(1'b1, 1'b0, '0);
    compute_row(1'b0, '0);
    compute_row(1'b0, ROW_W'(ROWS - 1));
  endtask

  task automatic test_unknown_ops();
    int i;
    for (i = 0; i < 6; i++) begin
      send_request(OP_W'($urandom_range(OP_COMPUTE + 1, (1 << OP_W) - 1)), 1'($urandom),
                   any_row(), any_comp(), VAL_W'($urandom));
      if (i == 2) compute_any_full();
    end
    compute_any_full();
  endtask

  task automatic test_backpressure();
    hold_toggle <= ~hold_toggle;
    repeat (3) compute_any_full();
    fill_row(1'($urandom), any_row(), 1'b0, '0);
    compute_any_full();
  endtask

  task automatic test_random();
    int start;
    int done;
    int pick;
    logic m;
    logic [ROW_W-1:0] r;
    logic [MEAN_AW-1:0] idx;
    start = requests_sent;
    done  = 0;
    while (done < RANDOM_ITEMS) begin
      idling_on <= !(done > RANDOM_ITEMS / 3 && done < RANDOM_ITEMS / 2);
      pick = $urandom_range(0, 99);
      m    = 1'($urandom);
      r    = any_row();
      idx  = full_rows[$urandom_range(0, full_rows.size() - 1)];
      if (pick < 4) begin
        fill_row(m, r, 1'b0, '0);
        compute_row(m, r);
      end else if (pick < 30) begin
        send_request(OP_LOAD_BASIS, idx[ROW_W], idx[ROW_W-1:0], any_comp(), pick_value());
      end else if (pick < 36) begin
        send_request(OP_LOAD_MEAN, idx[ROW_W], idx[ROW_W-1:0], any_comp(), pick_value());
      end else if (pick < 40) begin
        send_request(OP_LOAD_BASIS, m, r, any_comp(), pick_value());
      end else if (pick < 47) begin
        send_request(($urandom_range(0, 1) != 0) ? OP_LOAD_SCALE : OP_LOAD_COEFF, m, r,
                     any_comp(), ($urandom_range(0, 9) == 0) ? pick_value() : pick_weight());
      end else if (pick < 48) begin
        load_weights(m, 1'b0, '0);
      end else if (pick < 96) begin
        compute_any_full();
      end else begin
        send_request(OP_W'($urandom_range(OP_COMPUTE + 1, (1 << OP_W) - 1)), m, r,
                     any_comp(), VAL_W'($urandom));
      end
      done = requests_sent - start;
    end
    idling_on <= 1'b1;
  endtask

  // receiver side stall, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (idling_on) begin
      out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_elems.size() == 0) begin
        $error("unexpected result: model %0d row %0d value %0d", out_model, out_row,
               out_value);
        fails++;
      end else begin
        want = pending_elems.pop_front();
        if (out_model !== want.model) begin
          $error("out_model mismatch: expected %0d, got %0d", want.model, out_model);
          fails++;
        end
        if (out_row !== want.row) begin
          $error("out_row mismatch: expected %0d, got %0d", want.row, out_row);
          fails++;
        end
        if (out_value !== want.value) begin
          $error("out_value mismatch: expected %0d, got %0d", want.value, out_value);
          fails++;
        end
        if (out_saturated !== want.sat) begin
          $error("out_saturated mismatch: expected %0d, got %0d", want.sat, out_saturated);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_unknown_ops();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
